// ----- rtl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console writer package
// Transaction types, operation codes and sequencer states shared by the
// console writer and its screen memory.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam logic [2:0] MODE_PUT   = 3'd0;
    localparam logic [2:0] MODE_ERASE = 3'd1;
    localparam logic [2:0] MODE_HOME  = 3'd2;
    localparam logic [2:0] MODE_CLEAR = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] RESET_ATTR   = 8'h0F;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  char_code;
        logic [7:0]  attribute;
        logic [10:0] read_address;
    } t_in_item;

    typedef struct packed {
        logic [10:0] cursor_position;
        logic [15:0] read_data;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_DONE,
        S_SWEEP
    } t_state;

    typedef enum logic [1:0] {
        SWEEP_RESET,
        SWEEP_CLEAR,
        SWEEP_WRAP
    } t_sweep;

endpackage

// ----- rtl/tcw_screen_ram.sv -----
// ----------------------------------------------------------------------------
// Text console screen memory
// Single write port, single read port cell store with registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/text_console_writer_unit.sv -----
// ----------------------------------------------------------------------------
// Text console writer
// Screen cell store with a write cursor: put, erase-back, home, clear, read.
// ----------------------------------------------------------------------------
// An accepted transaction passes the execute and done states; a cell read adds a
//   read state for the registered memory read. The done state holds while the output
//   is held, and a new transaction is taken only in idle, once the last one is done.
// Clear screen walks every cell; a put with the cursor at the end first blanks
//   every cell, then retries. Reset blanks the store in a pass over every cell
//   with o_in_ready low; configuration writes are taken throughout.
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int CELLS   = 2000
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    localparam int AW   = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW   = $clog2(CELLS + 1);
    localparam int COLW = $clog2(COLUMNS + 1);
    localparam int NW   = $clog2(CELLS + COLUMNS + 1);
    localparam int END_COL = CELLS % COLUMNS;

    t_state          r_state, n_state;
    t_sweep          r_sweep_kind, n_sweep_kind;
    t_in_item        r_item;
    logic [CW-1:0]   r_cursor, n_cursor;
    logic [COLW-1:0] r_col, n_col;
    logic [AW-1:0]   r_sweep_addr, n_sweep_addr;
    logic [15:0]     r_fill, n_fill;
    logic [7:0]      r_blank_attr;
    logic [15:0]     r_rdata, n_rdata;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out_item, n_out_item;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [15:0]     ram_wdata;
    logic            ram_re;
    logic [15:0]     ram_rdata;
    logic [NW-1:0]   next_row;
    logic            in_accept;

    assign in_accept   = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign next_row = NW'(r_cursor) + NW'(COLUMNS) - NW'(r_col);

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (AW'(r_item.read_address)),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_sweep_kind = r_sweep_kind;
        n_cursor     = r_cursor;
        n_col        = r_col;
        n_sweep_addr = r_sweep_addr;
        n_fill       = r_fill;
        n_rdata      = r_rdata;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_item   = r_out_item;
        ram_we       = 1'b0;
        ram_waddr    = AW'(r_cursor);
        ram_wdata    = {r_item.attribute, r_item.char_code};
        ram_re       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_rdata = '0;
                n_state = S_DONE;
                unique case (r_item.mode)
                    MODE_PUT: begin
                        if (r_cursor >= CW'(CELLS)) begin
                            // wrap: blank the screen, home, then retry the put
                            n_cursor     = '0;
                            n_col        = '0;
                            n_fill       = {r_blank_attr, SPACE_CODE};
                            n_sweep_addr = '0;
                            n_sweep_kind = SWEEP_WRAP;
                            n_state      = S_SWEEP;
                        end else if (r_item.char_code == NEWLINE_CODE) begin
                            if (next_row > NW'(CELLS)) begin
                                n_cursor = CW'(CELLS);
                                n_col    = COLW'(END_COL);
                            end else begin
                                n_cursor = CW'(next_row);
                                n_col    = '0;
                            end
                        end else begin
                            ram_we   = 1'b1;
                            n_cursor = r_cursor + 1'b1;
                            n_col    = (r_col == COLW'(COLUMNS - 1)) ? '0 : r_col + 1'b1;
                        end
                    end
                    MODE_ERASE: begin
                        if (r_cursor != '0) begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(r_cursor - 1'b1);
                            ram_wdata = {r_blank_attr, SPACE_CODE};
                            n_cursor  = r_cursor - 1'b1;
                            n_col     = (r_col == '0) ? COLW'(COLUMNS - 1) : r_col - 1'b1;
                        end
                    end
                    MODE_HOME: begin
                        n_cursor = '0;
                        n_col    = '0;
                    end
                    MODE_CLEAR: begin
                        n_fill       = {r_blank_attr, SPACE_CODE};
                        n_sweep_addr = '0;
                        n_sweep_kind = SWEEP_CLEAR;
                        n_state      = S_SWEEP;
                    end
                    MODE_READ: begin
                        if (32'(r_item.read_address) < CELLS) begin
                            ram_re  = 1'b1;
                            n_state = S_READ;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_READ: begin
                n_rdata = ram_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_item  = '{cursor_position: 11'(r_cursor), read_data: r_rdata};
                    n_state     = S_IDLE;
                end
            end
            S_SWEEP: begin
                ram_we       = 1'b1;
                ram_waddr    = r_sweep_addr;
                ram_wdata    = r_fill;
                n_sweep_addr = r_sweep_addr + 1'b1;
                if (r_sweep_addr == AW'(CELLS - 1)) begin
                    unique case (r_sweep_kind)
                        SWEEP_RESET: n_state = S_IDLE;
                        SWEEP_CLEAR: n_state = S_DONE;
                        SWEEP_WRAP:  n_state = S_EXEC;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_sweep_kind <= SWEEP_RESET;
            r_sweep_addr <= '0;
            r_fill       <= {RESET_ATTR, SPACE_CODE};
            r_cursor     <= '0;
            r_col        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep_kind <= n_sweep_kind;
            r_sweep_addr <= n_sweep_addr;
            r_fill       <= n_fill;
            r_cursor     <= n_cursor;
            r_col        <= n_col;
            r_out_valid  <= n_out_valid;
        end
    end

    // blank attribute is held apart so that reset and writes stay independent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank_attr <= RESET_ATTR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_blank_attr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_in_item;
        end
        r_rdata    <= n_rdata;
        r_out_item <= n_out_item;
    end

    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cursor) <= CELLS)
        else $error("cursor beyond end of screen");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < COLUMNS)
        else $error("column tracker out of range");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_EXEC || r_state == S_SWEEP))
        else $error("screen write outside execute or sweep");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_EXEC))
        else $error("accepted transaction not executed");

endmodule
